// File: rtl/core/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants of the I2C master bit engine
// Command kinds, the queue entry carried from front to back, and widths.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int OP_W          = 3;
    localparam int BYTE_W        = 8;
    localparam int LIMIT_W       = 4;
    localparam int IDX_W         = 4;
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LIMIT_W-1:0] ACK_LIMIT_RESET = 4'd4;
    localparam logic [IDX_W-1:0]   BITS_PER_BYTE   = 4'd8;

    // operation codes as they arrive on the input channel
    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_START = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [BYTE_W-1:0] write_data;
        logic              send_nack;
        logic              sda_level;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// File: rtl/core/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front: input word decode
// Accept input words while the queue has room and classify the operation.
// ----------------------------------------------------------------------------
module i2cm_front (
    input  logic [i2cm_pkg::OP_W-1:0]       s_tuser,
    input  logic [i2cm_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  i2cm_pkg::q_status_t             q_status,
    output logic                            push,
    output i2cm_pkg::q_entry_t              push_entry
);
    import i2cm_pkg::*;

    cmd_t cmd;

    always_comb begin
        case (s_tuser)
            OP_START: cmd = CMD_START;
            OP_STOP:  cmd = CMD_STOP;
            OP_WRITE: cmd = CMD_WRITE;
            OP_READ:  cmd = CMD_READ;
            default:  cmd = CMD_TICK;   // tick only and unused codes
        endcase
    end

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && !q_status.full;

    assign push_entry.cmd        = cmd;
    assign push_entry.write_data = s_tdata[BYTE_W-1:0];
    assign push_entry.send_nack  = s_tdata[BYTE_W];
    assign push_entry.sda_level  = s_tdata[BYTE_W+1];

endmodule

// File: rtl/core/i2cm_queue.sv
// ----------------------------------------------------------------------------
// i2cm_queue: short word queue between decode and sequencer
// Register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module i2cm_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  i2cm_pkg::q_entry_t  push_entry,
    input  logic                pop,
    output i2cm_pkg::q_entry_t  head_entry,
    output i2cm_pkg::q_status_t q_status
);
    import i2cm_pkg::*;

    q_entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]     count_reg,  count_next;

    localparam logic [QCNT_W-1:0] DEPTH_CNT = QCNT_W'(QUEUE_DEPTH);
    localparam logic [QPTR_W-1:0] LAST_PTR  = QPTR_W'(QUEUE_DEPTH - 1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_entry     = slot_reg[rd_ptr_reg];
    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == DEPTH_CNT);

endmodule

// File: rtl/core/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq: I2C pin sequencer and result register
// Advance the bus sequence one quarter tick per word and register the result.
// ----------------------------------------------------------------------------
module i2cm_seq (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [i2cm_pkg::LIMIT_W-1:0]     cfg_wr_data,
    input  i2cm_pkg::q_entry_t               head_entry,
    input  i2cm_pkg::q_status_t              q_status,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [i2cm_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import i2cm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_START_A, S_START_B, S_START_C,
        S_STOP_A, S_STOP_B, S_STOP_C,
        S_WR_LOW, S_WR_HIGH, S_ACK_LOW, S_ACK_HIGH, S_ACK_POLL,
        S_RD_LOW, S_RD_HIGH, S_RA_HIGH, S_FINAL_LOW
    } seq_state_t;

    seq_state_t           state_reg, state_next;
    logic [IDX_W-1:0]     bit_idx_reg, bit_idx_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic                 phase_reg, phase_next;
    logic [LIMIT_W-1:0]   poll_cnt_reg, poll_cnt_next;
    logic                 scl_reg, scl_next;
    logic                 sda_en_reg, sda_en_next;
    logic                 sda_out_reg, sda_out_next;
    logic                 pend_nack_reg, pend_nack_next;
    logic [BYTE_W-1:0]    rd_byte_reg, rd_byte_next;
    logic                 nack_reg, nack_next;
    logic [LIMIT_W-1:0]   limit_reg;
    logic                 busy_next, done_next;
    logic                 out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                 run_half;
    logic                 sda_in;

    assign sda_in = head_entry.sda_level;
    assign pop    = !q_status.empty && (!out_valid_reg || m_tready);

    always_comb begin
        state_next     = state_reg;
        bit_idx_next   = bit_idx_reg;
        shift_next     = shift_reg;
        phase_next     = phase_reg;
        poll_cnt_next  = poll_cnt_reg;
        scl_next       = scl_reg;
        sda_en_next    = sda_en_reg;
        sda_out_next   = sda_out_reg;
        pend_nack_next = pend_nack_reg;
        rd_byte_next   = rd_byte_reg;
        nack_next      = nack_reg;
        busy_next      = 1'b0;
        done_next      = 1'b0;
        run_half       = 1'b1;

        // launch a command only from idle
        if (state_next == S_IDLE) begin
            phase_next = 1'b0;
            case (head_entry.cmd)
                CMD_START: state_next = S_START_A;
                CMD_STOP:  state_next = S_STOP_A;
                CMD_WRITE: begin
                    state_next   = S_WR_LOW;
                    shift_next   = head_entry.write_data;
                    bit_idx_next = BITS_PER_BYTE;
                end
                CMD_READ: begin
                    state_next     = S_RD_LOW;
                    shift_next     = '0;
                    bit_idx_next   = '0;
                    pend_nack_next = head_entry.send_nack;
                end
                default: state_next = S_IDLE;
            endcase
        end

        if (state_next != S_IDLE) begin
            busy_next = 1'b1;
            // ACK poll holds SCL high until ACK or the limit
            if (state_next == S_ACK_POLL) begin
                if (!sda_in || (poll_cnt_next >= limit_reg)) begin
                    nack_next  = sda_in;
                    state_next = S_FINAL_LOW;
                    phase_next = 1'b0;
                end else begin
                    poll_cnt_next = poll_cnt_next + 1'b1;
                    run_half      = 1'b0;
                end
            end
            if (run_half) begin
                if (!phase_next) begin
                    // first tick of a half step: SDA settings and sampling
                    phase_next = 1'b1;
                    case (state_next)
                        S_START_B: begin
                            sda_en_next  = 1'b1;
                            sda_out_next = 1'b1;
                        end
                        S_START_C: sda_out_next = 1'b0;
                        S_STOP_B: begin
                            sda_en_next  = 1'b1;
                            sda_out_next = 1'b0;
                        end
                        S_STOP_C:   sda_out_next = 1'b1;
                        S_WR_LOW:   sda_en_next  = 1'b1;
                        S_WR_HIGH: begin
                            sda_out_next = shift_next[BYTE_W-1];
                            shift_next   = {shift_next[BYTE_W-2:0], 1'b0};
                        end
                        S_ACK_HIGH: sda_en_next = 1'b0;
                        S_RD_LOW: begin
                            sda_en_next = 1'b0;
                            if (bit_idx_next >= IDX_W'(1) &&
                                bit_idx_next <= BITS_PER_BYTE) begin
                                shift_next = {shift_next[BYTE_W-2:0], sda_in};
                                if (bit_idx_next == BITS_PER_BYTE) begin
                                    rd_byte_next = shift_next;
                                end
                            end
                        end
                        S_RA_HIGH: begin
                            sda_en_next  = 1'b1;
                            sda_out_next = pend_nack_next;
                        end
                        default: ;
                    endcase
                end else begin
                    // second tick: SCL edge, then move on
                    phase_next = 1'b0;
                    case (state_next)
                        S_START_B, S_STOP_B, S_STOP_C, S_WR_HIGH,
                        S_ACK_HIGH, S_RD_HIGH, S_RA_HIGH: scl_next = 1'b1;
                        default:                          scl_next = 1'b0;
                    endcase
                    case (state_next)
                        S_START_A: state_next = S_START_B;
                        S_START_B: state_next = S_START_C;
                        S_STOP_A:  state_next = S_STOP_B;
                        S_STOP_B:  state_next = S_STOP_C;
                        S_WR_LOW:  state_next = S_WR_HIGH;
                        S_WR_HIGH: begin
                            bit_idx_next = bit_idx_next - 1'b1;
                            state_next   = (bit_idx_next == '0) ? S_ACK_LOW : S_WR_LOW;
                        end
                        S_ACK_LOW: state_next = S_ACK_HIGH;
                        S_ACK_HIGH: begin
                            poll_cnt_next = '0;
                            state_next    = S_ACK_POLL;
                        end
                        S_RD_LOW: begin
                            if (bit_idx_next < BITS_PER_BYTE) begin
                                state_next = S_RD_HIGH;
                            end else if (bit_idx_next == BITS_PER_BYTE) begin
                                bit_idx_next = BITS_PER_BYTE + 1'b1;
                            end else begin
                                state_next = S_RA_HIGH;
                            end
                        end
                        S_RD_HIGH: begin
                            bit_idx_next = bit_idx_next + 1'b1;
                            state_next   = S_RD_LOW;
                        end
                        S_RA_HIGH: state_next = S_FINAL_LOW;
                        default: begin
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            bit_idx_reg   <= '0;
            shift_reg     <= '0;
            phase_reg     <= 1'b0;
            poll_cnt_reg  <= '0;
            scl_reg       <= 1'b1;
            sda_en_reg    <= 1'b0;
            sda_out_reg   <= 1'b1;
            pend_nack_reg <= 1'b0;
            rd_byte_reg   <= '0;
            nack_reg      <= 1'b0;
            limit_reg     <= ACK_LIMIT_RESET;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (pop) begin
                state_reg     <= state_next;
                bit_idx_reg   <= bit_idx_next;
                shift_reg     <= shift_next;
                phase_reg     <= phase_next;
                poll_cnt_reg  <= poll_cnt_next;
                scl_reg       <= scl_next;
                sda_en_reg    <= sda_en_next;
                sda_out_reg   <= sda_out_next;
                pend_nack_reg <= pend_nack_next;
                rd_byte_reg   <= rd_byte_next;
                nack_reg      <= nack_next;
                out_valid_reg <= 1'b1;
                // result word, highest bit first
                out_data_reg  <= {2'b00, nack_next, rd_byte_next, done_next, busy_next,
                                  sda_out_next, sda_en_next, scl_next};
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: rtl/core/i2c_master_bit_engine_core.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core: I2C master pin sequencer
// Quarter-tick driven start/stop/write/read sequencer with stream ports.
// ----------------------------------------------------------------------------
// Each input word is one quarter period of the I2C bus: it carries the SDA
// level sampled in that quarter and, when the engine is idle, a command
// (start, stop, write byte, read byte; other codes are plain ticks). Every
// input word yields exactly one result word with the SCL level and SDA drive
// for that quarter, busy/done flags, the last read byte and the last ACK
// result. The engine takes one word per clock cycle while the result channel is
// not stalled. When the output register is free, a word accepted on the input is
// written into the queue, popped from there into the sequencer, and its result
// word is then held on m_tdata until the result channel takes it.
// While m_tready holds off, the result register and the two-entry queue fill
// and s_tready drops once three words are pending. The ack_poll_limit register
// (reset 4) is written through cfg_wr_en/cfg_wr_data and must only change
// while no word is in flight. Multi-byte transfers and the stop after a final
// read are issued by the host.
module i2c_master_bit_engine_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration: ack_poll_limit
    input  logic                             cfg_wr_en,
    input  logic [i2cm_pkg::LIMIT_W-1:0]     cfg_wr_data,
    // input channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] write_data, [8] send_nack, [9] sda_level, [15:10] zero
    input  logic [i2cm_pkg::IN_TDATA_W-1:0]  s_tdata,
    // [2:0] operation
    input  logic [i2cm_pkg::OP_W-1:0]        s_tuser,
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] scl_level, [1] sda_drive_enable, [2] sda_drive_level, [3] busy_res,
    // [4] done_res, [12:5] read_data, [13] nack_seen, [15:14] zero
    output logic [i2cm_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import i2cm_pkg::*;

    logic      push;
    logic      pop;
    q_entry_t  push_entry;
    q_entry_t  head_entry;
    q_status_t q_status;

    // front: accept and classify words
    i2cm_front u_front (
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // queue: let front and sequencer stall independently
    i2cm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    // back: run the bus sequence and hold the result word
    i2cm_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head_entry  (head_entry),
        .q_status    (q_status),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// File: rtl/core/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker: port-level checks of the I2C master bit engine
// Observe the result channel and flag inconsistent words.
// ----------------------------------------------------------------------------
module i2cm_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [i2cm_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import i2cm_pkg::*;

    logic                   prev_valid_reg;
    logic [OUT_TDATA_W-1:0] prev_word_reg;
    logic                   m_accept;

    assign m_accept = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_valid_reg <= 1'b0;
        end else if (m_accept) begin
            prev_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_accept) begin
            prev_word_reg <= m_tdata;
        end
    end

    // a finishing tick is always part of a sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[3])
        else $error("done without busy");

    // an idle tick leaves pins, read byte and ACK flag as they were
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_accept && prev_valid_reg && !m_tdata[3] |->
            m_tdata[13:0] == {prev_word_reg[13:5], 1'b0, 1'b0, prev_word_reg[2:0]})
        else $error("idle tick changed bus or result state");

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

endmodule

bind i2c_master_bit_engine_core i2cm_checker u_i2cm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: dv/tb_i2c_master_bit_engine_core.sv
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_engine_core: self-checking bench for the I2C bit engine
// Streams quarter-tick words through the engine and compares every result
// word with a bus-level predictor. A short table of directed ticks opens the
// run, then whole start/write/read/stop transfers with random bytes, random
// slave ACK timing and noise. It steps through several ACK poll limits and
// throttles both streams at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine_core;
    import i2cm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 60;
    localparam int PHASES      = 5;
    localparam int ACK_NEVER   = 99;

    // spare operation codes: the engine treats them as plain ticks
    localparam logic [OP_W-1:0] OP_UNUSED_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    // how the fake slave drives SDA outside the ACK poll
    localparam int SDA_RANDOM = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_LOW    = 2;

    // result word as it sits in m_tdata[13:0], scl_level in the lowest bit
    typedef struct packed {
        logic              nack_seen;
        logic [BYTE_W-1:0] read_data;
        logic              done;
        logic              busy;
        logic              sda_lvl;
        logic              sda_en;
        logic              scl;
    } bus_word_t;

    // bus idle: SCL high, SDA released, drive level high, nothing seen yet
    localparam bus_word_t IDLE_WORD = 14'h0005;

    typedef enum logic [3:0] {
        SQ_IDLE, SQ_START_A, SQ_START_B, SQ_START_C,
        SQ_STOP_A, SQ_STOP_B, SQ_STOP_C, SQ_WR_LOW,
        SQ_WR_HIGH, SQ_ACK_LOW, SQ_ACK_HIGH, SQ_ACK_POLL,
        SQ_RD_LOW, SQ_RD_HIGH, SQ_RA_HIGH, SQ_FINAL_LOW
    } seq_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data;
        logic              nack;
        logic              sda;
        bit                typed;
        bus_word_t         word;
    } dir_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [LIMIT_W-1:0]     cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // [7:0] write_data, [8] send_nack, [9] sda_level
    logic [OP_W-1:0]        s_tuser;   // [2:0] operation
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [0] scl, [1] sda_en, [2] sda_lvl, [3] busy,
                                       // [4] done, [12:5] read_data, [13] nack_seen

    // predictor copy of the engine state
    logic [LIMIT_W-1:0] poll_limit;
    seq_t               sq;
    logic [IDX_W-1:0]   bit_idx;
    logic [BYTE_W-1:0]  shreg;
    logic               ph_tick;
    logic [LIMIT_W-1:0] poll_cnt;
    logic               scl_q, sda_en_q, sda_q, nack_pend, nack_q;
    logic [BYTE_W-1:0]  rd_q;

    bus_word_t bus_words_due[$];
    int        items_sent;
    int        words_seen;
    int        fail_count;
    int        cycles;

    // directed ticks; only the idle words are typed in, the rest are predicted
    dir_row_t dir_tab [0:16] = '{
        '{OP_TICK,     8'h00, 1'b0, 1'b0, 1'b1, IDLE_WORD},  // first word after reset
        '{OP_UNUSED_5, 8'hff, 1'b1, 1'b1, 1'b1, IDLE_WORD},  // spare codes stay idle
        '{OP_UNUSED_6, 8'h5a, 1'b0, 1'b0, 1'b1, IDLE_WORD},
        '{OP_UNUSED_7, 8'ha5, 1'b1, 1'b0, 1'b1, IDLE_WORD},
        '{OP_START,    8'h00, 1'b0, 1'b1, 1'b0, '0},         // start condition, six ticks
        '{OP_WRITE,    8'hff, 1'b1, 1'b0, 1'b0, '0},         // commands while busy: dropped
        '{OP_READ,     8'h00, 1'b1, 1'b1, 1'b0, '0},
        '{OP_STOP,     8'h80, 1'b0, 1'b0, 1'b0, '0},
        '{OP_TICK,     8'h01, 1'b0, 1'b1, 1'b0, '0},
        '{OP_TICK,     8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{OP_STOP,     8'hff, 1'b1, 1'b1, 1'b0, '0},         // stop condition, six ticks
        '{OP_START,    8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b0, '0},
        '{OP_UNUSED_7, 8'hff, 1'b1, 1'b0, 1'b0, '0},
        '{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b0, '0},
        '{OP_TICK,     8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b0, '0}          // idle again after the stop
    };

    i2c_master_bit_engine_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Advance the bus sequencer by one quarter tick and return the word it shows.
    task automatic predict_tick(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] wdata,
                                input logic nack, input logic sda, output bus_word_t w);
        logic busy, done, run;
        begin
            busy = 1'b0;
            done = 1'b0;
            run  = 1'b1;
            // commands are taken only from idle
            if (sq == SQ_IDLE) begin
                ph_tick = 1'b0;
                case (op)
                    OP_START: sq = SQ_START_A;
                    OP_STOP:  sq = SQ_STOP_A;
                    OP_WRITE: begin
                        sq      = SQ_WR_LOW;
                        shreg   = wdata;
                        bit_idx = BITS_PER_BYTE;
                    end
                    OP_READ: begin
                        sq        = SQ_RD_LOW;
                        shreg     = '0;
                        bit_idx   = '0;
                        nack_pend = nack;
                    end
                    default: ;
                endcase
            end
            if (sq != SQ_IDLE) begin
                busy = 1'b1;
                // hold SCL high until the slave pulls SDA low or the limit runs out
                if (sq == SQ_ACK_POLL) begin
                    if (sda == 1'b0 || poll_cnt >= poll_limit) begin
                        nack_q  = sda;
                        sq      = SQ_FINAL_LOW;
                        ph_tick = 1'b0;
                    end else begin
                        poll_cnt = poll_cnt + 1'b1;
                        run      = 1'b0;
                    end
                end
                if (run && !ph_tick) begin
                    // first tick of a half step: SDA moves, SCL holds
                    ph_tick = 1'b1;
                    case (sq)
                        SQ_START_B: begin sda_en_q = 1'b1; sda_q = 1'b1; end
                        SQ_START_C: sda_q = 1'b0;
                        SQ_STOP_B:  begin sda_en_q = 1'b1; sda_q = 1'b0; end
                        SQ_STOP_C:  sda_q = 1'b1;
                        SQ_WR_LOW:  sda_en_q = 1'b1;
                        SQ_WR_HIGH: begin
                            sda_q = shreg[BYTE_W-1];
                            shreg = shreg << 1;
                        end
                        SQ_ACK_HIGH: sda_en_q = 1'b0;
                        SQ_RD_LOW: begin
                            sda_en_q = 1'b0;
                            if (bit_idx >= IDX_W'(1) && bit_idx <= BITS_PER_BYTE) begin
                                shreg = {shreg[BYTE_W-2:0], sda};
                                if (bit_idx == BITS_PER_BYTE)
                                    rd_q = shreg;
                            end
                        end
                        SQ_RA_HIGH: begin sda_en_q = 1'b1; sda_q = nack_pend; end
                        default: ;
                    endcase
                end else if (run) begin
                    // second tick: SCL takes the level of the half step
                    ph_tick = 1'b0;
                    case (sq)
                        SQ_START_B, SQ_STOP_B, SQ_STOP_C, SQ_WR_HIGH,
                        SQ_ACK_HIGH, SQ_RD_HIGH, SQ_RA_HIGH: scl_q = 1'b1;
                        default: scl_q = 1'b0;
                    endcase
                    case (sq)
                        SQ_START_A: sq = SQ_START_B;
                        SQ_START_B: sq = SQ_START_C;
                        SQ_STOP_A:  sq = SQ_STOP_B;
                        SQ_STOP_B:  sq = SQ_STOP_C;
                        SQ_WR_LOW:  sq = SQ_WR_HIGH;
                        SQ_WR_HIGH: begin
                            bit_idx = bit_idx - 1'b1;
                            sq = (bit_idx == '0) ? SQ_ACK_LOW : SQ_WR_LOW;
                        end
                        SQ_ACK_LOW: sq = SQ_ACK_HIGH;
                        SQ_ACK_HIGH: begin
                            poll_cnt = '0;
                            sq = SQ_ACK_POLL;
                        end
                        SQ_RD_LOW: begin
                            // one extra low half step after the eighth bit
                            if (bit_idx < BITS_PER_BYTE)
                                sq = SQ_RD_HIGH;
                            else if (bit_idx == BITS_PER_BYTE)
                                bit_idx = BITS_PER_BYTE + 1'b1;
                            else
                                sq = SQ_RA_HIGH;
                        end
                        SQ_RD_HIGH: begin
                            bit_idx = bit_idx + 1'b1;
                            sq = SQ_RD_LOW;
                        end
                        SQ_RA_HIGH: sq = SQ_FINAL_LOW;
                        default: begin
                            sq   = SQ_IDLE;
                            done = 1'b1;
                        end
                    endcase
                end
            end
            w.scl       = scl_q;
            w.sda_en    = sda_en_q;
            w.sda_lvl   = sda_q;
            w.busy      = busy;
            w.done      = done;
            w.read_data = rd_q;
            w.nack_seen = nack_q;
        end
    endtask

    // Offer one word after a random gap, wait for the handshake, then predict.
    task automatic push_word(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] wdata,
                             input logic nack, input logic sda,
                             input bit typed = 1'b0, input bus_word_t typed_word = '0);
        int gap, r;
        bus_word_t w;
        begin
            r = $urandom_range(0, 19);
            if (((items_sent / 48) % 4) == 2 || r < 11)
                gap = 0;
            else if (r < 18)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(8, 30);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk);
            s_tvalid <= 1'b1;
            s_tuser  <= op;
            s_tdata  <= {{(IN_TDATA_W-BYTE_W-2){1'b0}}, sda, nack, wdata};
            do @(posedge aclk); while (!s_tready);
            predict_tick(op, wdata, nack, sda, w);
            bus_words_due.push_back(typed ? typed_word : w);
            items_sent++;
        end
    endtask

    // Issue one command, then tick until the sequencer is idle again.
    task automatic run_command(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] wdata,
                               input logic nack, input int ack_after, input int sda_mode,
                               input bit noisy);
        int polls;
        logic sda;
        logic [OP_W-1:0] cur_op;
        logic [BYTE_W-1:0] cur_data;
        begin
            polls    = 0;
            cur_op   = op;
            cur_data = wdata;
            do begin
                if (sq == SQ_ACK_POLL) begin
                    // the slave answers after a chosen number of poll ticks
                    sda = (polls >= ack_after) ? 1'b0 : 1'b1;
                    polls++;
                end else begin
                    case (sda_mode)
                        SDA_HIGH: sda = 1'b1;
                        SDA_LOW:  sda = 1'b0;
                        default:  sda = 1'($urandom_range(0, 1));
                    endcase
                end
                push_word(cur_op, cur_data, nack, sda);
                // noise: stray commands while busy must be ignored
                if (noisy && $urandom_range(0, 5) == 0)
                    cur_op = OP_W'($urandom_range(0, 7));
                else
                    cur_op = OP_TICK;
                cur_data = BYTE_W'($urandom_range(0, 255));
            end while (sq != SQ_IDLE);
        end
    endtask

    function automatic int pick_ack_delay();
        int r;
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
                pick_ack_delay = 0;
            else if (r < 8)
                pick_ack_delay = $urandom_range(0, poll_limit + 2);
            else
                pick_ack_delay = ACK_NEVER;
        end
    endfunction

    // One bus transfer: start, one to three bytes written or read, stop; now and then noise or a lone command.
    task automatic random_transfer();
        int n;
        bit noisy;
        begin
            noisy = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                run_command(OP_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), pick_ack_delay(), SDA_RANDOM, 1'b1);
            end else begin
                run_command(OP_START, BYTE_W'($urandom_range(0, 255)), 1'b0, 0, SDA_RANDOM,
                            noisy);
                n = $urandom_range(1, 3);
                repeat (n) begin
                    if ($urandom_range(0, 1))
                        run_command(OP_WRITE, BYTE_W'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1)), pick_ack_delay(), SDA_RANDOM,
                                    noisy);
                    else
                        run_command(OP_READ, BYTE_W'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1)), 0, $urandom_range(0, 2), noisy);
                end
                run_command(OP_STOP, BYTE_W'($urandom_range(0, 255)), 1'b0, 0, SDA_RANDOM,
                            noisy);
            end
        end
    endtask

    // Drop valid and wait until every predicted word has come back.
    task automatic settle_bus();
        begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            while (bus_words_due.size() != 0) @(posedge aclk);
            repeat (4) @(posedge aclk);
        end
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        begin
            if (exp_v != got_v) begin
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, got_v);
                fail_count++;
            end
        end
    endtask

    // result side: compare each accepted word with the oldest prediction
    always @(posedge aclk) begin
        bus_word_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            got = m_tdata[13:0];
            if (bus_words_due.size() == 0) begin
                $display("%0t: unexpected word: expected none, got %0h", $time, m_tdata);
                fail_count++;
            end else begin
                want = bus_words_due.pop_front();
                check_field("scl_level",        32'(want.scl),       32'(got.scl));
                check_field("sda_drive_enable", 32'(want.sda_en),    32'(got.sda_en));
                check_field("sda_drive_level",  32'(want.sda_lvl),   32'(got.sda_lvl));
                check_field("busy",             32'(want.busy),      32'(got.busy));
                check_field("done",             32'(want.done),      32'(got.done));
                check_field("read_data",        32'(want.read_data), 32'(got.read_data));
                check_field("nack_seen",        32'(want.nack_seen), 32'(got.nack_seen));
            end
        end
    end

    // result side: throttle m_tready, with one long hold-off to back the engine up
    initial begin
        int hold;
        bit long_hold_done;
        hold = 0;
        long_hold_done = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else if (!long_hold_done && words_seen >= 100) begin
                long_hold_done = 1'b1;
                hold = 79;
                m_tready <= 1'b0;
            end else if (((words_seen / 64) % 4) != 1 && $urandom_range(0, 3) == 0) begin
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                   : $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int p, i, phase_base;
        bit paused;
        logic [LIMIT_W-1:0] new_limit;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_TICK;
        items_sent  = 0;
        words_seen  = 0;
        fail_count  = 0;
        paused      = 1'b0;

        poll_limit = ACK_LIMIT_RESET;
        sq         = SQ_IDLE;
        bit_idx    = '0;
        shreg      = '0;
        ph_tick    = 1'b0;
        poll_cnt   = '0;
        scl_q      = 1'b1;
        sda_en_q   = 1'b0;
        sda_q      = 1'b1;
        nack_pend  = 1'b0;
        nack_q     = 1'b0;
        rd_q       = '0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                // change the poll limit only with the engine idle and drained
                settle_bus();
                case (p)
                    1:       new_limit = '0;
                    2:       new_limit = '1;
                    3:       new_limit = LIMIT_W'($urandom_range(1, 14));
                    default: new_limit = ACK_LIMIT_RESET;
                endcase
                @(negedge aclk);
                cfg_wr_en   <= 1'b1;
                cfg_wr_data <= new_limit;
                @(negedge aclk);
                cfg_wr_en   <= 1'b0;
                poll_limit = new_limit;
            end else begin
                for (i = 0; i < 17; i++)
                    push_word(dir_tab[i].op, dir_tab[i].data, dir_tab[i].nack, dir_tab[i].sda,
                              dir_tab[i].typed, dir_tab[i].word);
                // byte extremes: all ones with no ACK, all zeros with an instant ACK,
                // then reads of all ones with NACK and all zeros with ACK
                run_command(OP_WRITE, 8'hff, 1'b0, ACK_NEVER, SDA_RANDOM, 1'b0);
                run_command(OP_WRITE, 8'h00, 1'b1, 0, SDA_RANDOM, 1'b0);
                run_command(OP_READ, 8'h00, 1'b1, 0, SDA_HIGH, 1'b0);
                run_command(OP_READ, 8'hff, 1'b0, 0, SDA_LOW, 1'b0);
            end
            phase_base = items_sent;
            while (items_sent - phase_base < PHASE_ITEMS) begin
                // once, let the result stream run dry in the middle of a phase
                if (p == 1 && !paused && items_sent - phase_base >= PHASE_ITEMS / 2) begin
                    settle_bus();
                    paused = 1'b1;
                end
                random_transfer();
            end
        end

        settle_bus();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_front.sv
rtl/core/i2cm_queue.sv
rtl/core/i2cm_seq.sv
rtl/core/i2c_master_bit_engine_core.sv
rtl/core/i2cm_checker.sv
dv/tb_i2c_master_bit_engine_core.sv
